// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Depends on a clock named clock and a reset named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is low.
`define LBS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every edge, reset included.
`define LBS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/lbs_pkg.sv =====
// Types, codes and fixed-point helpers for the linear blend skinning block.
// No dependencies.
package lbs_pkg;

   localparam logic [1:0] KIND_BIND   = 2'd0;
   localparam logic [1:0] KIND_DEFORM = 2'd1;
   localparam logic [1:0] KIND_INFL   = 2'd2;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   typedef enum logic [1:0] {OP_BIND, OP_DEFORM, OP_INFL} op_type;

   typedef enum logic [3:0] {
      S_IDLE, S_LOAD,
      S_RB_RD, S_RB_MUL, S_RB_ACC, S_RB_WR,
      S_IN_RD, S_IN_MUL, S_IN_ACC, S_IN_RND, S_IN_WMUL, S_IN_ADD,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic [5:0]         bone_index;
      logic [3:0]         element_index;
      logic signed [31:0] element_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic [16:0]        weight;
      logic               last_influence;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_pos_x;
      logic signed [31:0] out_pos_y;
      logic signed [31:0] out_pos_z;
      logic signed [31:0] out_norm_x;
      logic signed [31:0] out_norm_y;
      logic signed [31:0] out_norm_z;
   } rsp_type;

   typedef struct packed {
      op_type             op;
      logic               bone_ok;
      logic [5:0]         bone;
      logic [3:0]         elem;
      logic signed [31:0] value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] norm_x;
      logic signed [31:0] norm_y;
      logic signed [31:0] norm_z;
      logic [16:0]        weight;
      logic               last;
   } cmd_type;

   function automatic logic signed [31:0] sat_to_32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) return 32'sh7fffffff;
      else if (x < -66'sd2147483648) return 32'sh80000000;
      else return x[31:0];
   endfunction

   function automatic logic signed [47:0] sat_to_48(input logic signed [65:0] x);
      if (x > 66'sd140737488355327) return 48'sh7fffffffffff;
      else if (x < -66'sd140737488355328) return 48'sh800000000000;
      else return x[47:0];
   endfunction

   // Nearest, ties toward plus infinity, from Q.48 down to Q.24 scaling.
   function automatic logic signed [65:0] round_q24(input logic signed [65:0] x);
      return (x + 66'sd8388608) >>> 24;
   endfunction

endpackage

// ===== src/lbs_fifo.sv =====
// Small first-in first-out queue of flat words.
// No dependencies.
module lbs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] data_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = data_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) data_ff[wr_ptr_ff] <= push_data;
   end
endmodule

// ===== src/lbs_front.sv =====
// Front end: accepts input words, classifies them and queues commands.
// Depends on lbs_pkg and lbs_fifo.
module lbs_front #(
   parameter int MAX_BONES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lbs_pkg::req_type req_data,
   output logic             cmd_valid,
   input  logic             cmd_pop,
   output lbs_pkg::cmd_type cmd
);
   import lbs_pkg::*;

   cmd_type cls;
   logic    keep;
   logic    q_empty;
   logic [$bits(cmd_type)-1:0] q_data;

   always_comb begin
      cls.bone_ok = (32'(req_data.bone_index) < MAX_BONES);
      cls.bone    = req_data.bone_index;
      cls.elem    = req_data.element_index;
      cls.value   = req_data.element_value;
      cls.pos_x   = req_data.pos_x;
      cls.pos_y   = req_data.pos_y;
      cls.pos_z   = req_data.pos_z;
      cls.norm_x  = req_data.norm_x;
      cls.norm_y  = req_data.norm_y;
      cls.norm_z  = req_data.norm_z;
      cls.weight  = (req_data.weight > WEIGHT_ONE) ? WEIGHT_ONE : req_data.weight;
      cls.last    = req_data.last_influence;
      cls.op      = OP_INFL;
      keep        = 1'b0;
      case (req_data.kind)
         KIND_BIND: begin
            cls.op = OP_BIND;
            keep   = cls.bone_ok;
         end
         KIND_DEFORM: begin
            cls.op = OP_DEFORM;
            keep   = cls.bone_ok;
         end
         KIND_INFL: begin
            cls.op = OP_INFL;
            keep   = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   lbs_fifo #(.WIDTH($bits(cmd_type)), .DEPTH(4)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && keep),
      .push_data (cls),
      .full      (req_full),
      .pop       (cmd_pop),
      .empty     (q_empty),
      .pop_data  (q_data)
   );

   assign cmd_valid = !q_empty;
   assign cmd       = cmd_type'(q_data);
endmodule

// ===== src/lbs_back.sv =====
// Back end: pose memories, skin matrix rebuild and influence accumulation;
// the rebuild shares the position multiplier. Depends on lbs_pkg.
module lbs_back #(
   parameter int MAX_BONES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  lbs_pkg::cmd_type cmd,
   output logic             cmd_pop,
   input  logic             deform_normals,
   input  logic             out_full,
   output logic             out_push,
   output lbs_pkg::rsp_type out_data
);
   import lbs_pkg::*;

   localparam int BW    = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
   localparam int AW    = BW + 4;
   localparam int DEPTH = MAX_BONES * 16;

   logic [31:0] bind_mem_ff   [0:DEPTH-1];
   logic [31:0] deform_mem_ff [0:DEPTH-1];
   logic [31:0] skin_mem_ff   [0:DEPTH-1];
   logic signed [31:0] bind_q_ff, deform_q_ff, skin_q_ff;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in;
   logic signed [63:0] prod_p_ff, prod_p_in, prod_n_ff, prod_n_in;
   logic signed [65:0] sum_p_ff, sum_p_in, sum_n_ff, sum_n_in;
   logic signed [47:0] t_p_ff, t_p_in, t_n_ff, t_n_in;
   logic signed [65:0] w_p_ff, w_p_in, w_n_ff, w_n_in;
   logic signed [47:0] pacc_ff [0:2];
   logic signed [47:0] pacc_in [0:2];
   logic signed [47:0] nacc_ff [0:2];
   logic signed [47:0] nacc_in [0:2];

   logic [AW-1:0] bind_raddr, deform_raddr, skin_raddr, waddr;
   logic we_bind, we_deform, we_skin;
   logic signed [31:0] skin_wdata;
   logic signed [31:0] mul_a, mul_b, pos_k, norm_k;
   logic signed [63:0] mul_p, mul_n;

   assign bind_raddr   = AW'({cmd_ff.bone, r_ff, k_ff});
   assign deform_raddr = AW'({cmd_ff.bone, k_ff, c_ff});
   assign skin_raddr   = AW'({cmd_ff.bone, k_ff, c_ff});

   always_comb begin
      case (k_ff)
         2'd0: begin pos_k = cmd_ff.pos_x; norm_k = cmd_ff.norm_x; end
         2'd1: begin pos_k = cmd_ff.pos_y; norm_k = cmd_ff.norm_y; end
         default: begin pos_k = cmd_ff.pos_z; norm_k = cmd_ff.norm_z; end
      endcase
   end

   // The position multiplier also serves the matrix product during a rebuild.
   assign mul_a = (state_ff == S_RB_MUL) ? bind_q_ff : pos_k;
   assign mul_b = (state_ff == S_RB_MUL) ? deform_q_ff : skin_q_ff;
   assign mul_p = mul_a * mul_b;
   assign mul_n = norm_k * skin_q_ff;

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      prod_p_in = prod_p_ff;
      prod_n_in = prod_n_ff;
      sum_p_in  = sum_p_ff;
      sum_n_in  = sum_n_ff;
      t_p_in    = t_p_ff;
      t_n_in    = t_n_ff;
      w_p_in    = w_p_ff;
      w_n_in    = w_n_ff;
      pacc_in   = pacc_ff;
      nacc_in   = nacc_ff;
      cmd_pop   = 1'b0;
      out_push  = 1'b0;
      we_bind   = 1'b0;
      we_deform = 1'b0;
      we_skin   = 1'b0;
      waddr     = AW'({cmd_ff.bone, cmd_ff.elem});
      skin_wdata = sat_to_32(round_q24(sum_p_ff));
      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop  = 1'b1;
               cmd_in   = cmd;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
               sum_p_in = '0;
               sum_n_in = '0;
               case (cmd.op)
                  OP_BIND, OP_DEFORM: state_in = S_LOAD;
                  OP_INFL: begin
                     if (cmd.bone_ok) state_in = S_IN_RD;
                     else if (cmd.last) state_in = S_EMIT;
                     else state_in = S_IDLE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD: begin
            we_bind   = (cmd_ff.op == OP_BIND);
            we_deform = (cmd_ff.op == OP_DEFORM);
            state_in  = S_RB_RD;
         end
         S_RB_RD:  state_in = S_RB_MUL;
         S_RB_MUL: begin
            prod_p_in = mul_p;
            state_in  = S_RB_ACC;
         end
         S_RB_ACC: begin
            sum_p_in = sum_p_ff + 66'(prod_p_ff);
            if (k_ff == 2'd3) begin
               state_in = S_RB_WR;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_RB_RD;
            end
         end
         S_RB_WR: begin
            we_skin  = 1'b1;
            waddr    = AW'({cmd_ff.bone, r_ff, c_ff});
            sum_p_in = '0;
            k_in     = '0;
            c_in     = c_ff + 1'b1;
            state_in = S_RB_RD;
            if (c_ff == 2'd3) begin
               r_in = r_ff + 1'b1;
               if (r_ff == 2'd3) state_in = S_IDLE;
            end
         end
         S_IN_RD:  state_in = S_IN_MUL;
         S_IN_MUL: begin
            // The fourth row is the translation, applied to points only.
            if (k_ff == 2'd3) begin
               prod_p_in = $signed({{16{skin_q_ff[31]}}, skin_q_ff, 16'b0});
               prod_n_in = '0;
            end else begin
               prod_p_in = mul_p;
               prod_n_in = mul_n;
            end
            state_in = S_IN_ACC;
         end
         S_IN_ACC: begin
            sum_p_in = sum_p_ff + 66'(prod_p_ff);
            sum_n_in = sum_n_ff + 66'(prod_n_ff);
            if (k_ff == 2'd3) begin
               state_in = S_IN_RND;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = S_IN_RD;
            end
         end
         S_IN_RND: begin
            t_p_in   = sat_to_48(round_q24(sum_p_ff));
            t_n_in   = sat_to_48(round_q24(sum_n_ff));
            state_in = S_IN_WMUL;
         end
         S_IN_WMUL: begin
            w_p_in   = t_p_ff * $signed({1'b0, cmd_ff.weight});
            w_n_in   = t_n_ff * $signed({1'b0, cmd_ff.weight});
            state_in = S_IN_ADD;
         end
         S_IN_ADD: begin
            pacc_in[c_ff] = sat_to_48(66'(pacc_ff[c_ff]) + ((w_p_ff + 66'sd32768) >>> 16));
            nacc_in[c_ff] = sat_to_48(66'(nacc_ff[c_ff]) + ((w_n_ff + 66'sd32768) >>> 16));
            sum_p_in = '0;
            sum_n_in = '0;
            k_in     = '0;
            if (c_ff == 2'd2) begin
               state_in = cmd_ff.last ? S_EMIT : S_IDLE;
            end else begin
               c_in     = c_ff + 1'b1;
               state_in = S_IN_RD;
            end
         end
         S_EMIT: begin
            if (!out_full) begin
               out_push = 1'b1;
               for (int i = 0; i < 3; i++) begin
                  pacc_in[i] = '0;
                  nacc_in[i] = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      out_data.out_pos_x = sat_to_32(66'(pacc_ff[0]));
      out_data.out_pos_y = sat_to_32(66'(pacc_ff[1]));
      out_data.out_pos_z = sat_to_32(66'(pacc_ff[2]));
      if (deform_normals) begin
         out_data.out_norm_x = sat_to_32(66'(nacc_ff[0]));
         out_data.out_norm_y = sat_to_32(66'(nacc_ff[1]));
         out_data.out_norm_z = sat_to_32(66'(nacc_ff[2]));
      end else begin
         out_data.out_norm_x = cmd_ff.norm_x;
         out_data.out_norm_y = cmd_ff.norm_y;
         out_data.out_norm_z = cmd_ff.norm_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         for (int i = 0; i < 3; i++) begin
            pacc_ff[i] <= '0;
            nacc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pacc_ff  <= pacc_in;
         nacc_ff  <= nacc_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      r_ff      <= r_in;
      c_ff      <= c_in;
      k_ff      <= k_in;
      prod_p_ff <= prod_p_in;
      prod_n_ff <= prod_n_in;
      sum_p_ff  <= sum_p_in;
      sum_n_ff  <= sum_n_in;
      t_p_ff    <= t_p_in;
      t_n_ff    <= t_n_in;
      w_p_ff    <= w_p_in;
      w_n_ff    <= w_n_in;
   end

   always_ff @(posedge clock) begin
      if (we_bind) bind_mem_ff[waddr] <= cmd_ff.value;
      bind_q_ff <= bind_mem_ff[bind_raddr];
   end

   always_ff @(posedge clock) begin
      if (we_deform) deform_mem_ff[waddr] <= cmd_ff.value;
      deform_q_ff <= deform_mem_ff[deform_raddr];
   end

   always_ff @(posedge clock) begin
      if (we_skin) skin_mem_ff[waddr] <= skin_wdata;
      skin_q_ff <= skin_mem_ff[skin_raddr];
   end
endmodule

// ===== src/linear_blend_skinning.sv =====
// Linear blend skinning. A pose element load holds the back end through dispatch, one write,
// then 16 skin elements, each of 4 products (read, multiply, accumulate) and a write.
// A point influence holds it through dispatch, then per coordinate 4 products (read,
// multiply, accumulate) plus rounding, weighting and accumulation. The last influence adds
// an emit step, which waits while the result queue is full; items run one at a time.
// Synchronous reset empties both queues and clears the accumulators; memories are not cleared.
module linear_blend_skinning #(
   parameter int MAX_BONES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lbs_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output lbs_pkg::rsp_type rsp_data,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import lbs_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_pop;
   logic    out_full, out_push;
   rsp_type out_data;
   logic [$bits(rsp_type)-1:0] rsp_bits;
   logic    deform_ff, deform_in;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {31'd0, deform_ff};

   always_comb begin
      deform_in = deform_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && !csr_paddr[2]) begin
         deform_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) deform_ff <= 1'b0;
      else deform_ff <= deform_in;
   end

   lbs_front #(.MAX_BONES(MAX_BONES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   lbs_back #(.MAX_BONES(MAX_BONES)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (cmd_valid),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop),
      .deform_normals (deform_ff),
      .out_full       (out_full),
      .out_push       (out_push),
      .out_data       (out_data)
   );

   lbs_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(2)) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .pop_data  (rsp_bits)
   );

   assign rsp_data = rsp_type'(rsp_bits);
endmodule

// ===== src/lbs_checker.sv =====
// Port-level checks for the skinning block, bound to its top level.
// Depends on lbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_full,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input lbs_pkg::rsp_type rsp_data,
   input logic             csr_pready
);
   `LBS_ASSERT_ALWAYS(a_empty_after_reset, reset |=> rsp_empty, "result queue not empty after reset")
   `LBS_ASSERT_ALWAYS(a_open_after_reset, reset |=> !req_full, "input queue full after reset")
   `LBS_ASSERT(a_word_held, (!rsp_empty && !rsp_pop) |=> !rsp_empty, "waiting word was dropped")
   `LBS_ASSERT(a_word_stable, (!rsp_empty && !rsp_pop) |=> $stable(rsp_data), "waiting word changed")
   `LBS_ASSERT(a_pready_high, csr_pready, "register port not ready")
endmodule

bind linear_blend_skinning lbs_checker u_lbs_checker (.*);

// ===== sim/linear_blend_skinning_test.sv =====
// Self-checking testbench for linear_blend_skinning: loads pose matrices, streams point
// influences, and compares every result word against an in-bench fixed-point predictor.
// Depends on lbs_pkg and the linear_blend_skinning RTL.
`timescale 1ns / 100ps

module linear_blend_skinning_test;
   import lbs_pkg::*;

   localparam logic [1:0] KIND_NONE = 2'd3;
   localparam logic [2:0] ADDR_DEFORM_NORMALS = 3'd0;
   localparam int DEPTH = 64 * 16;
   localparam int DRAIN_CYCLES = 1500;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam longint ACC_HI = 64'sd140737488355327;
   localparam longint ACC_LO = -64'sd140737488355328;

   typedef longint vec4_type[4];

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   rsp_type rsp_data;
   logic csr_psel = 0;
   logic csr_penable = 0;
   logic csr_pwrite = 0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Predictor state.
   int bind_tab[DEPTH];
   int deform_tab[DEPTH];
   int skin_tab[DEPTH];
   longint pos_acc[3];
   longint nrm_acc[3];
   bit deform_normals;

   rsp_type expected_words[$];
   int errors = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   longint cycles = 0;
   int live_bones[$] = '{0, 1, 2, 3, 4, 5, 6, 7, 63};

   linear_blend_skinning dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------- predictor ----------------

   function automatic longint dot_q24(vec4_type a, vec4_type b, int n);
      longint hi = 0;
      longint lo = 64'sd8388608;
      longint p;
      for (int i = 0; i < n; i++) begin
         p = a[i] * b[i];
         hi += p >>> 24;
         lo += p & 64'shFFFFFF;
      end
      return hi + (lo >>> 24);
   endfunction

   function automatic longint clamp(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   function automatic void rebuild_skin(int base);
      vec4_type a, b;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
               a[k] = bind_tab[base + r*4 + k];
               b[k] = deform_tab[base + k*4 + c];
            end
            skin_tab[base + r*4 + c] = int'(clamp(dot_q24(a, b, 4), -64'sd2147483648,
                                                  64'sd2147483647));
         end
   endfunction

   function automatic longint weighted_add(longint acc, longint t, longint w);
      longint v = clamp(t, ACC_LO, ACC_HI);
      longint c = (v * w + 32768) >>> 16;
      return clamp(acc + c, ACC_LO, ACC_HI);
   endfunction

   // Updates the predictor for one accepted item; queues a word on the last influence.
   function automatic void predict_item(req_type it);
      int base = int'(it.bone_index) * 16;
      vec4_type p, n, m;
      longint w;
      rsp_type r;
      if (it.kind == KIND_BIND || it.kind == KIND_DEFORM) begin
         if (it.kind == KIND_BIND) bind_tab[base + it.element_index] = it.element_value;
         else deform_tab[base + it.element_index] = it.element_value;
         rebuild_skin(base);
         return;
      end
      if (it.kind != KIND_INFL) return;
      w = it.weight > WEIGHT_ONE ? 65536 : longint'(it.weight);
      p = '{it.pos_x, it.pos_y, it.pos_z, 65536};
      n = '{it.norm_x, it.norm_y, it.norm_z, 0};
      for (int c = 0; c < 3; c++) begin
         for (int k = 0; k < 4; k++) m[k] = skin_tab[base + k*4 + c];
         pos_acc[c] = weighted_add(pos_acc[c], dot_q24(p, m, 4), w);
         nrm_acc[c] = weighted_add(nrm_acc[c], dot_q24(n, m, 3), w);
      end
      if (!it.last_influence) return;
      r.out_pos_x = 32'(clamp(pos_acc[0], -64'sd2147483648, 64'sd2147483647));
      r.out_pos_y = 32'(clamp(pos_acc[1], -64'sd2147483648, 64'sd2147483647));
      r.out_pos_z = 32'(clamp(pos_acc[2], -64'sd2147483648, 64'sd2147483647));
      if (deform_normals) begin
         r.out_norm_x = 32'(clamp(nrm_acc[0], -64'sd2147483648, 64'sd2147483647));
         r.out_norm_y = 32'(clamp(nrm_acc[1], -64'sd2147483648, 64'sd2147483647));
         r.out_norm_z = 32'(clamp(nrm_acc[2], -64'sd2147483648, 64'sd2147483647));
      end else begin
         r.out_norm_x = it.norm_x;
         r.out_norm_y = it.norm_y;
         r.out_norm_z = it.norm_z;
      end
      for (int c = 0; c < 3; c++) begin
         pos_acc[c] = 0;
         nrm_acc[c] = 0;
      end
      expected_words.insert(expected_words.size(), r);
   endfunction

   // ---------------- result side ----------------

   always @(posedge clock) rsp_pop <= ($urandom_range(99) >= stall_pct);

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %h, got %h", name, exp_v, act_v);
         errors++;
      end
   endfunction

   // Outputs only change at rising edges, so the falling edge sees what the next edge takes.
   always @(negedge clock) begin
      rsp_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word %h", rsp_data);
            errors++;
         end else begin
            e = expected_words.pop_front();
            check_field("out_pos_x", e.out_pos_x, rsp_data.out_pos_x);
            check_field("out_pos_y", e.out_pos_y, rsp_data.out_pos_y);
            check_field("out_pos_z", e.out_pos_z, rsp_data.out_pos_z);
            check_field("out_norm_x", e.out_norm_x, rsp_data.out_norm_x);
            check_field("out_norm_y", e.out_norm_y, rsp_data.out_norm_y);
            check_field("out_norm_z", e.out_norm_z, rsp_data.out_norm_z);
         end
      end
   end

   // ---------------- stimulus helpers ----------------

   task automatic send_word(req_type it);
      if ($urandom_range(99) < gap_pct) begin
         req_push <= 0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push <= 1;
      req_data <= it;
      do @(negedge clock); while (req_full);
      @(posedge clock);
      predict_item(it);
   endtask

   task automatic wait_idle();
      req_push <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_deform_normals(bit v);
      wait_idle();
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= ADDR_DEFORM_NORMALS;
      csr_pwdata <= {31'b0, v};
      @(posedge clock) csr_penable <= 1;
      @(posedge clock) begin
         deform_normals = v;
         csr_pwrite <= 0;
         csr_penable <= 0;
      end
      @(posedge clock) csr_penable <= 1;
      @(negedge clock);
      if (csr_prdata[0] !== v) begin
         $error("deform_normals: expected %0d, got %0d", v, csr_prdata[0]);
         errors++;
      end
      @(posedge clock) begin
         csr_psel <= 0;
         csr_penable <= 0;
      end
   endtask

   // Near-identity elements with a modest translation row keep most results unsaturated.
   function automatic int pose_value(int elem);
      int r = elem / 4, c = elem % 4;
      if ($urandom_range(9) == 0) return $urandom;
      if (c == 3) return (r == 3) ? 32'sh01000000 : 0;
      if (r == 3) return $signed($urandom_range(0, 32'h07ffffff)) - 32'sh04000000;
      return (r == c ? 32'sh01000000 : 0) + $signed($urandom_range(0, 32'h00ffffff))
             - 32'sh00800000;
   endfunction

   function automatic int coord_value();
      if ($urandom_range(9) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
   endfunction

   function automatic req_type load_word(logic [1:0] kind, int bone, int elem, int val);
      req_type it = '0;
      it.kind = kind;
      it.bone_index = 6'(bone);
      it.element_index = 4'(elem);
      it.element_value = val;
      it.last_influence = 1'($urandom_range(1));
      it.weight = 17'($urandom);
      it.pos_x = $urandom;
      return it;
   endfunction

   function automatic req_type influence_word(int bone, bit last);
      req_type it;
      int pick = $urandom_range(9);
      it = '0;
      it.kind = KIND_INFL;
      it.bone_index = 6'(bone);
      it.element_index = 4'($urandom);
      it.element_value = $urandom;
      it.pos_x = coord_value();
      it.pos_y = coord_value();
      it.pos_z = coord_value();
      it.norm_x = coord_value();
      it.norm_y = coord_value();
      it.norm_z = coord_value();
      it.weight = pick == 0 ? WEIGHT_ONE : pick == 1 ? 17'($urandom_range(65537, 131071))
                  : 17'($urandom_range(0, 65536));
      it.last_influence = last;
      return it;
   endfunction

   // ---------------- tests ----------------

   // Every bone that is used later gets all of its bind and deform elements written first.
   task automatic test_bone_setup();
      foreach (live_bones[i])
         for (int e = 0; e < 16; e++) begin
            send_word(load_word(KIND_BIND, live_bones[i], e, pose_value(e)));
            send_word(load_word(KIND_DEFORM, live_bones[i], e, pose_value(e)));
         end
   endtask

   task automatic test_directed();
      req_type it;
      // A point with no influences: one entry of weight zero.
      it = influence_word(0, 1);
      it.weight = 0;
      send_word(it);
      it = influence_word(63, 1);
      it.weight = WEIGHT_ONE;
      send_word(it);
      it = influence_word(1, 1);
      it.weight = 17'h1ffff;
      send_word(it);
      // Extreme coordinates.
      it = influence_word(2, 0);
      {it.pos_x, it.pos_y, it.pos_z} = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      {it.norm_x, it.norm_y, it.norm_z} = {32'sh80000000, 32'sh7fffffff, 32'sh80000000};
      send_word(it);
      it = influence_word(2, 1);
      {it.pos_x, it.pos_y, it.pos_z} = {32'sh80000000, 32'sh7fffffff, 32'sh00000000};
      send_word(it);
      // Unknown kind, with last set, must leave no trace.
      it = influence_word(3, 1);
      it.kind = KIND_NONE;
      send_word(it);
      // Extreme matrix values on bone 63 drive the outputs into saturation.
      send_word(load_word(KIND_BIND, 63, 0, 32'sh7fffffff));
      send_word(load_word(KIND_DEFORM, 63, 0, 32'sh7fffffff));
      send_word(load_word(KIND_BIND, 63, 5, 32'sh80000000));
      send_word(load_word(KIND_DEFORM, 63, 15, 32'sh80000000));
      it = influence_word(63, 0);
      {it.pos_x, it.pos_y, it.pos_z} = {32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
      it.weight = WEIGHT_ONE;
      send_word(it);
      it = influence_word(63, 1);
      {it.norm_x, it.norm_y, it.norm_z} = {32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      it.weight = WEIGHT_ONE;
      send_word(it);
      // Restore bone 63 to moderate values.
      send_word(load_word(KIND_BIND, 63, 0, 32'sh01000000));
      send_word(load_word(KIND_DEFORM, 63, 0, 32'sh01000000));
      send_word(load_word(KIND_BIND, 63, 5, 32'sh01000000));
      send_word(load_word(KIND_DEFORM, 63, 15, 32'sh01000000));
   endtask

   task automatic test_random_phase(int gap, int stall, bit dn, int count);
      int done = 0;
      int pick, len, bone;
      req_type it;
      write_deform_normals(dn);
      gap_pct = gap;
      stall_pct = stall;
      while (done < count) begin
         pick = $urandom_range(99);
         bone = live_bones[$urandom_range(live_bones.size() - 1)];
         if (pick < 10) begin
            len = $urandom_range(15);
            send_word(load_word($urandom_range(1) ? KIND_BIND : KIND_DEFORM, bone, len,
                                pose_value(len)));
            done++;
         end else if (pick < 13) begin
            it = influence_word(bone, $urandom_range(1));
            it.kind = KIND_NONE;
            send_word(it);
         end else begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
               bone = live_bones[$urandom_range(live_bones.size() - 1)];
               send_word(influence_word(bone, i == len - 1));
               done++;
            end
         end
      end
      gap_pct = 0;
   endtask

   initial begin
      foreach (bind_tab[i]) begin
         bind_tab[i] = 0;
         deform_tab[i] = 0;
         skin_tab[i] = 0;
      end
      for (int c = 0; c < 3; c++) begin
         pos_acc[c] = 0;
         nrm_acc[c] = 0;
      end
      deform_normals = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_bone_setup();
      write_deform_normals(1);
      test_directed();
      write_deform_normals(0);
      test_directed();
      test_random_phase(0, 0, 1, 400);
      test_random_phase(53, 0, 0, 400);
      test_random_phase(0, 53, 1, 400);
      test_random_phase(19, 19, 0, 400);
      wait_idle();
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
